// File: design/text_console_char_writer_macros.svh
// Assertion macros for the text console character writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst is high.
`define TCW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text console check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text console check failed");

`else

`define TCW_ASSERT_IMPL(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: design/tcw_pkg.sv
// Shared field widths, codes and constants of the text console.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int ACTION_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int CELL_W     = 16;
  localparam int COLOUR_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [COLOUR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'h0;

  // Blank cell after reset: space, white on black.
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

endpackage

// File: design/tcw_channels.sv
// Valid/ready channel interfaces for console requests and results.
`timescale 1ns / 1ps

interface tcw_item_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]   char_code;
  logic [INDEX_W-1:0]  cell_index;

  modport source (output valid, action, char_code, cell_index, input ready);
  modport sink (input valid, action, char_code, cell_index, output ready);
endinterface

interface tcw_result_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] cursor_index;
  logic [CELL_W-1:0]  cell_value;

  modport source (output valid, cursor_index, cell_value, input ready);
  modport sink (input valid, cursor_index, cell_value, output ready);
endinterface

// File: design/text_console_char_writer.sv
// Text console: screen store, cursor and character/clear/read sequencer.
//
// A printable character, return, newline without scroll, backspace and a
// cell read go from acceptance through S_DONE to the result register.
// Clear and scroll walk the screen store one cell per cycle through its
// single write port (a scroll first copies the kept rows, one read and one
// write per cycle, then blanks the vacated rows, and a character that
// waits on it is written after it). After reset the store is swept to
// blanks, all COLUMNS*ROWS cells (2000 by default), while item.ready stays
// low; configuration writes are taken throughout. The next request is
// taken while a finished result waits on the result channel.
`timescale 1ns / 1ps
`include "text_console_char_writer_macros.svh"

module text_console_char_writer import tcw_pkg::*; #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int SCROLL_LINES = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  tcw_item_if.sink              item,
  tcw_result_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(CELL_COUNT + 1);
  localparam int CLW        = $clog2(COLUMNS + 1);
  localparam int RW         = $clog2(ROWS + 1);
  localparam int SHIFT_ROWS = (SCROLL_LINES < ROWS) ? SCROLL_LINES : ROWS;
  localparam int COPY_LEN   = (ROWS - SHIFT_ROWS) * COLUMNS;
  localparam int SRC_OFF    = SHIFT_ROWS * COLUMNS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_COPY = 6'b000010,
    S_FILL = 6'b000100,
    S_FIX  = 6'b001000,
    S_PUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    K_INIT   = 2'd0,
    K_CLEAR  = 2'd1,
    K_SCROLL = 2'd2
  } fill_kind_t;

  localparam state_t SCROLL_START = (COPY_LEN > 0) ? S_COPY : S_FILL;

  state_t              state, state_next;
  fill_kind_t          kind, kind_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CLW-1:0]      col, col_next;
  logic [RW-1:0]       row, row_next;
  logic                pend, pend_next;
  logic [CHAR_W-1:0]   chr_q, chr_next;
  logic                rd_hit, rd_hit_next;
  logic [COLOUR_W-1:0] fg, bg;
  logic                out_valid;
  logic [INDEX_W-1:0]  out_cursor;
  logic [CELL_W-1:0]   out_cell;
  logic                load;

  logic [CELL_W-1:0]   screen [CELL_COUNT];
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [CELL_W-1:0]   mem_wd;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [CELL_W-1:0]   rd_q;

  logic [CELL_W-1:0]   blank;
  logic                wrap;
  logic [CLW-1:0]      wcol, bcol;
  logic [RW-1:0]       wrow, brow;

  function automatic logic [CW-1:0] lin_of(input logic [CLW-1:0] c,
                                           input logic [RW-1:0] r);
    lin_of = CW'(CW'(r) * CW'(COLUMNS)) + CW'(c);
  endfunction

  assign blank = {bg, fg, CHAR_SPACE};

  // Column wrap ahead of a printable character.
  assign wrap = (col == CLW'(COLUMNS));
  assign wcol = wrap ? '0 : col;
  assign wrow = wrap ? row + RW'(1) : row;

  // Backspace target; stays at the home cell.
  always_comb begin
    if (col != '0) begin
      bcol = col - CLW'(1);
      brow = row;
    end else if (row != '0) begin
      bcol = CLW'(COLUMNS - 1);
      brow = row - RW'(1);
    end else begin
      bcol = '0;
      brow = '0;
    end
  end

  always_comb begin
    state_next  = state;
    kind_next   = kind;
    cnt_next    = cnt;
    col_next    = col;
    row_next    = row;
    pend_next   = pend;
    chr_next    = chr_q;
    rd_hit_next = rd_hit;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = blank;
    rd_en       = 1'b0;
    rd_addr     = '0;
    load        = 1'b0;

    case (state)
      S_IDLE: begin
        if (item.valid) begin
          rd_hit_next = 1'b0;
          pend_next   = 1'b0;
          state_next  = S_DONE;
          case (action_t'(item.action))
            ACT_PUT: begin
              if (item.char_code == CHAR_CR) begin
                col_next = '0;
              end else if (item.char_code == CHAR_LF) begin
                col_next = '0;
                row_next = row + RW'(1);
                if (int'(row) + 1 >= ROWS) begin
                  kind_next  = K_SCROLL;
                  cnt_next   = '0;
                  state_next = SCROLL_START;
                end
              end else if (item.char_code == CHAR_BS) begin
                col_next = bcol;
                row_next = brow;
                mem_we   = 1'b1;
                mem_wa   = AW'(lin_of(bcol, brow));
              end else if (int'(wrow) >= ROWS) begin
                // Hold the character until the scroll is done.
                col_next   = wcol;
                row_next   = wrow;
                pend_next  = 1'b1;
                chr_next   = item.char_code;
                kind_next  = K_SCROLL;
                cnt_next   = '0;
                state_next = SCROLL_START;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = AW'(lin_of(wcol, wrow));
                mem_wd   = {bg, fg, item.char_code};
                col_next = wcol + CLW'(1);
                row_next = wrow;
              end
            end
            ACT_CLEAR: begin
              kind_next  = K_CLEAR;
              cnt_next   = '0;
              state_next = S_FILL;
            end
            ACT_READ: begin
              if (int'(item.cell_index) < CELL_COUNT) begin
                rd_en       = 1'b1;
                rd_addr     = AW'(item.cell_index);
                rd_hit_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_COPY: begin
        // Read ahead, write one behind.
        if (cnt != CW'(COPY_LEN)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cnt + CW'(SRC_OFF));
        end
        if (cnt != '0) begin
          mem_we = 1'b1;
          mem_wa = AW'(cnt - CW'(1));
          mem_wd = rd_q;
        end
        if (cnt == CW'(COPY_LEN)) begin
          state_next = S_FILL;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = AW'(cnt);
        mem_wd = (kind == K_INIT) ? RESET_CELL : blank;
        if (cnt == CW'(CELL_COUNT - 1)) begin
          case (kind)
            K_INIT: state_next = S_IDLE;
            K_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              state_next = S_DONE;
            end
            K_SCROLL: state_next = S_FIX;
            default: state_next = S_IDLE;
          endcase
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      S_FIX: begin
        if (int'(row) >= SCROLL_LINES) begin
          row_next = RW'(int'(row) - SCROLL_LINES);
        end else begin
          row_next = '0;
          col_next = '0;
        end
        state_next = pend ? S_PUT : S_DONE;
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_wa     = AW'(lin_of(col, row));
        mem_wd     = {bg, fg, chr_q};
        col_next   = col + CLW'(1);
        pend_next  = 1'b0;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_FILL;
      kind   <= K_INIT;
      cnt    <= '0;
      col    <= '0;
      row    <= '0;
      pend   <= 1'b0;
      rd_hit <= 1'b0;
    end else begin
      state  <= state_next;
      kind   <= kind_next;
      cnt    <= cnt_next;
      col    <= col_next;
      row    <= row_next;
      pend   <= pend_next;
      rd_hit <= rd_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    chr_q <= chr_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= screen[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FG: fg <= cfg_data;
        REG_BG: bg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cursor <= INDEX_W'(lin_of(col, row));
      out_cell   <= rd_hit ? rd_q : '0;
    end
  end

  assign item.ready          = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.cursor_index = out_cursor;
  assign result.cell_value   = out_cell;

  `TCW_ASSERT_IMPL(a_idle_cursor, state == S_IDLE, (int'(row) < ROWS) && (int'(col) <= COLUMNS))
  `TCW_ASSERT_IMPL(a_done_no_write, state == S_DONE, !mem_we)
  `TCW_ASSERT_NEXT(a_accept_busy, item.valid && item.ready, state != S_IDLE)
  `TCW_ASSERT_NEXT(a_done_loads, load, result.valid && (state == S_IDLE))

endmodule
